// ===== rtl/core/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [6:0] char_t;
	typedef logic [3:0] len_t;
	typedef logic [3:0] digit_t;

	localparam opcode_t OP_UDEC = 2'd0;
	localparam opcode_t OP_SDEC = 2'd1;
	localparam opcode_t OP_HEX  = 2'd2;

	localparam char_t CH_ZERO  = 7'h30;
	localparam char_t CH_A     = 7'h61;
	localparam char_t CH_MINUS = 7'h2d;

	localparam digit_t DIGIT_TEN = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic char_t digit_char(input digit_t d);
		if (d < DIGIT_TEN) begin
			digit_char = CH_ZERO + char_t'(d);
		end else begin
			digit_char = CH_A + char_t'(d - DIGIT_TEN);
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itoa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface itoa_num_if #(parameter int W = 32);
	logic         valid;
	logic         ready;
	logic [W-1:0] value;
	logic [1:0]   opcode;

	modport source (output valid, output value, output opcode, input ready);
	modport sink   (input valid, input value, input opcode, output ready);
endinterface

interface itoa_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] character;
	logic [3:0] length;
	logic       last;

	modport source (output valid, output character, output length, output last, input ready);
	modport sink   (input valid, input character, input length, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/itoa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_front
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	itoa_num_if.sink               number,
	input  queue_status_t          status,
	output logic                   push,
	output logic [VALUE_WIDTH+1:0] push_data
);

	logic                   neg;
	logic                   hex;
	logic [VALUE_WIDTH-1:0] mag;

	// sign and magnitude, hex always unsigned
	always_comb begin
		neg = (number.opcode == OP_SDEC) && number.value[VALUE_WIDTH-1];
		hex = number.opcode[1];
		mag = neg ? (~number.value + 1'b1) : number.value;
	end

	assign number.ready = !status.full;
	assign push         = number.valid && !status.full;
	assign push_data    = {hex, neg, mag};

endmodule

`default_nettype wire

// ===== rtl/core/itoa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_queue
	import itoa_pkg::*;
#(
	parameter int WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output queue_status_t    status
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	assign pop_data     = entry_q[rd_q];
	assign status.full  = count_q[1];
	assign status.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// ===== rtl/core/itoa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_back
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  queue_status_t          status,
	input  logic [VALUE_WIDTH+1:0] pop_data,
	output logic                   pop,
	itoa_text_if.source            text
);

	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int DW   = 4 * NDIG;
	localparam int CW   = $clog2(VALUE_WIDTH + 1);
	localparam int RW   = $clog2(NDIG + 1);

	back_state_t            state_q, state_d;
	logic [VALUE_WIDTH-1:0] bin_q, bin_d;
	logic [DW-1:0]          bcd_q, bcd_d;
	logic [CW-1:0]          cnt_q, cnt_d;
	logic [RW-1:0]          rem_q, rem_d;
	logic                   neg_q, neg_d;
	logic                   started_q, started_d;
	len_t                   len_q, len_d;

	logic                   ovalid_q, ovalid_d;
	char_t                  ochar_q, ochar_d;
	len_t                   olen_q, olen_d;
	logic                   olast_q, olast_d;

	logic                   out_free;
	logic [DW-1:0]          bcd_adj;
	digit_t                 top;
	digit_t                 dig;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			dig = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
		end
	end

	assign top      = bcd_q[DW-1 -: 4];
	assign out_free = !ovalid_q || text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		bin_q     <= bin_d;
		bcd_q     <= bcd_d;
		cnt_q     <= cnt_d;
		rem_q     <= rem_d;
		neg_q     <= neg_d;
		started_q <= started_d;
		len_q     <= len_d;
		ochar_q   <= ochar_d;
		olen_q    <= olen_d;
		olast_q   <= olast_d;
	end

	always_comb begin
		state_d   = state_q;
		bin_d     = bin_q;
		bcd_d     = bcd_q;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		neg_d     = neg_q;
		started_d = started_q;
		len_d     = len_q;
		ovalid_d  = ovalid_q && !text.ready;
		ochar_d   = ochar_q;
		olen_d    = olen_q;
		olast_d   = olast_q;
		pop       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!status.empty) begin
					pop       = 1'b1;
					neg_d     = pop_data[VALUE_WIDTH];
					rem_d     = RW'(NDIG);
					started_d = 1'b0;
					len_d     = '0;
					if (pop_data[VALUE_WIDTH+1]) begin
						bcd_d   = DW'(pop_data[VALUE_WIDTH-1:0]);
						state_d = ST_EMIT;
					end else begin
						bin_d   = pop_data[VALUE_WIDTH-1:0];
						bcd_d   = '0;
						cnt_d   = CW'(VALUE_WIDTH);
						state_d = ST_CONV;
					end
				end
			end
			ST_CONV: begin
				bcd_d = {bcd_adj[DW-2:0], bin_q[VALUE_WIDTH-1]};
				bin_d = bin_q << 1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (neg_q) begin
					if (out_free) begin
						ovalid_d = 1'b1;
						ochar_d  = CH_MINUS;
						olen_d   = len_q + 1'b1;
						olast_d  = 1'b0;
						len_d    = len_q + 1'b1;
						neg_d    = 1'b0;
					end
				end else if (!started_q && top == '0 && rem_q != RW'(1)) begin
					// leading zero
					bcd_d = bcd_q << 4;
					rem_d = rem_q - 1'b1;
				end else if (out_free) begin
					ovalid_d  = 1'b1;
					ochar_d   = digit_char(top);
					olen_d    = len_q + 1'b1;
					olast_d   = (rem_q == RW'(1));
					len_d     = len_q + 1'b1;
					started_d = 1'b1;
					bcd_d     = bcd_q << 4;
					rem_d     = rem_q - 1'b1;
					if (rem_q == RW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign text.valid     = ovalid_q;
	assign text.character = ochar_q;
	assign text.length    = olen_q;
	assign text.last      = olast_q;

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// channel  dir  handshake     payload
// number   in   valid/ready   value[VALUE_WIDTH], opcode[2]
// text     out  valid/ready   character[7], length[4], last[1]
//
// each item is popped from the queue, then decimal items go through shift-add-3
// conversion over all VALUE_WIDTH bits, then one bcd digit position per cycle is
// emitted while text is not stalled (leading zeros skipped one per cycle), after a
// minus sign if any; hex items skip the conversion and are emitted the same way
// a two-entry queue lets new items be taken while the back end converts
// arst_n clears the control state only; text stalls hold the output register
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	itoa_num_if.sink    number,
	itoa_text_if.source text
);

	localparam int QW = VALUE_WIDTH + 2;

	queue_status_t status;
	logic          push;
	logic          pop;
	logic [QW-1:0] push_data;
	logic [QW-1:0] pop_data;

	itoa_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.number    (number),
		.status    (status),
		.push      (push),
		.push_data (push_data)
	);

	itoa_queue #(.WIDTH(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (status)
	);

	itoa_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.pop_data (pop_data),
		.pop      (pop),
		.text     (text)
	);

endmodule

`default_nettype wire
